// File: design/button_servo_gate_led_sequencer_assert.svh
// Assertion macros for the button / servo / LED sequencer.
// No dependencies; included by modules that carry concurrent checks.
`ifndef BUTTON_SERVO_GATE_LED_SEQUENCER_ASSERT_SVH
`define BUTTON_SERVO_GATE_LED_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BSGL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer check failed");

// next-cycle implication, disabled during reset
`define BSGL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer check failed");

`endif

// File: design/bsgl_pkg.sv
// Shared widths, register indexes, reset values and fade phase codes
// for the button / servo / LED sequencer. No dependencies.
package bsgl_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;
   localparam int SERVO_W     = 15;
   localparam int COUNT_W     = 8;

   localparam int FLASH_RELOAD_DEFAULT = 6;
   localparam int CHASER_LEDS_DEFAULT  = 5;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_CHASER_ON_SLOW = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHASER_PAUSE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_RISE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_ON_SLOW   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_FALL      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERVO_LOW      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERVO_HIGH     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SERVO_STEP     = 3'd7;

   // register reset values
   localparam logic [COUNT_W-1:0] CHASER_ON_SLOW_RESET = 8'd12;
   localparam logic [COUNT_W-1:0] CHASER_PAUSE_RESET   = 8'd12;
   localparam logic [COUNT_W-1:0] FADE_RISE_RESET      = 8'd1;
   localparam logic [COUNT_W-1:0] HOLD_ON_SLOW_RESET   = 8'd2;
   localparam logic [COUNT_W-1:0] FADE_FALL_RESET      = 8'd2;
   localparam logic [SERVO_W-1:0] SERVO_LOW_RESET      = 15'd750;
   localparam logic [SERVO_W-1:0] SERVO_HIGH_RESET     = 15'd2200;
   localparam logic [SERVO_W-1:0] SERVO_STEP_RESET     = 15'd7;

   // press duration window in ticks
   localparam logic [COUNT_W-1:0] PRESS_MIN_TICKS  = 8'd5;
   localparam logic [COUNT_W-1:0] PRESS_LONG_TICKS = 8'd50;
   localparam logic [COUNT_W-1:0] DUTY_FULL        = 8'd255;

   // inner LED fade phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RISE = 2'd1;
   localparam logic [1:0] PH_ON   = 2'd2;
   localparam logic [1:0] PH_FALL = 2'd3;

endpackage

// File: design/bsgl_req_if.sv
// Input channel of the sequencer: one tick item with two button levels.
// No dependencies.
interface bsgl_req_if;
   logic valid;
   logic ready;
   logic inner_pressed;
   logic outer_pressed;

   modport source (output valid, inner_pressed, outer_pressed, input ready);
   modport sink (input valid, inner_pressed, outer_pressed, output ready);
endinterface

// File: design/bsgl_rsp_if.sv
// Result channel of the sequencer: servo, chaser, fade and gate LED state.
// Uses bsgl_pkg for widths and the chaser width default.
interface bsgl_rsp_if #(
   parameter int CHASER_LEDS = bsgl_pkg::CHASER_LEDS_DEFAULT
);
   logic                        valid;
   logic                        ready;
   logic [bsgl_pkg::SERVO_W-1:0] servo_width;
   logic                        servo_powered;
   logic [CHASER_LEDS-1:0]      chaser_leds;
   logic [bsgl_pkg::COUNT_W-1:0] fade_duty;
   logic                        fade_pwm_active;
   logic                        inner_led_steady;
   logic                        gate_led;
   logic                        deep_sleep_ok;

   modport source (output valid, servo_width, servo_powered, chaser_leds, fade_duty,
                   fade_pwm_active, inner_led_steady, gate_led, deep_sleep_ok,
                   input ready);
   modport sink (input valid, servo_width, servo_powered, chaser_leds, fade_duty,
                 fade_pwm_active, inner_led_steady, gate_led, deep_sleep_ok,
                 output ready);
endinterface

// File: design/button_servo_gate_led_sequencer.sv
// Button, servo gate and LED sequencer: one tick item in, one result item out.
// An accepted tick passes the input register, then the state and result register,
// whose valid the sink drains. Throughput: 1 item per cycle while the sink takes
// results, set by the single-pass state update between the two registers.
// Reset (synchronous, active high) clears control state, loads the register
// defaults and empties both stages. Uses bsgl_pkg, bsgl_req_if and bsgl_rsp_if.
`include "button_servo_gate_led_sequencer_assert.svh"

module button_servo_gate_led_sequencer #(
   parameter int FLASH_RELOAD = bsgl_pkg::FLASH_RELOAD_DEFAULT,
   parameter int CHASER_LEDS  = bsgl_pkg::CHASER_LEDS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   bsgl_req_if.sink                            req_ch,
   bsgl_rsp_if.source                          rsp_ch,
   input  logic                                csr_write_en,
   input  logic [bsgl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bsgl_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int CW = bsgl_pkg::COUNT_W;
   localparam int SW = bsgl_pkg::SERVO_W;
   localparam logic [CW-1:0] FLASH_LOAD  = CW'(FLASH_RELOAD);
   // highest single-LED pattern; anything above has walked off the end
   localparam logic [CW-1:0] CHASER_LAST = CW'(1) << (CHASER_LEDS - 1);

   // ---------------- configuration registers ----------------
   logic [CW-1:0] chaser_on_ff, chaser_pause_cfg_ff, rise_step_ff, hold_on_ff;
   logic [CW-1:0] fall_step_ff;
   logic [SW-1:0] servo_low_ff, servo_high_ff, servo_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chaser_on_ff        <= bsgl_pkg::CHASER_ON_SLOW_RESET;
         chaser_pause_cfg_ff <= bsgl_pkg::CHASER_PAUSE_RESET;
         rise_step_ff        <= bsgl_pkg::FADE_RISE_RESET;
         hold_on_ff          <= bsgl_pkg::HOLD_ON_SLOW_RESET;
         fall_step_ff        <= bsgl_pkg::FADE_FALL_RESET;
         servo_low_ff        <= bsgl_pkg::SERVO_LOW_RESET;
         servo_high_ff       <= bsgl_pkg::SERVO_HIGH_RESET;
         servo_step_ff       <= bsgl_pkg::SERVO_STEP_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            bsgl_pkg::CSR_CHASER_ON_SLOW: chaser_on_ff        <= csr_write_data[CW-1:0];
            bsgl_pkg::CSR_CHASER_PAUSE:   chaser_pause_cfg_ff <= csr_write_data[CW-1:0];
            bsgl_pkg::CSR_FADE_RISE:      rise_step_ff        <= csr_write_data[CW-1:0];
            bsgl_pkg::CSR_HOLD_ON_SLOW:   hold_on_ff          <= csr_write_data[CW-1:0];
            bsgl_pkg::CSR_FADE_FALL:      fall_step_ff        <= csr_write_data[CW-1:0];
            bsgl_pkg::CSR_SERVO_LOW:      servo_low_ff        <= csr_write_data[SW-1:0];
            bsgl_pkg::CSR_SERVO_HIGH:     servo_high_ff       <= csr_write_data[SW-1:0];
            bsgl_pkg::CSR_SERVO_STEP:     servo_step_ff       <= csr_write_data[SW-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline handshake ----------------
   // Input register holds one accepted tick; it moves into the state and
   // result register once the result slot is free or being drained.
   logic in_valid_ff, in_inner_ff, in_outer_ff;
   logic rsp_valid_ff;
   logic advance;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_inner_ff <= req_ch.inner_pressed;
         in_outer_ff <= req_ch.outer_pressed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // ---------------- sequencer state ----------------
   logic [CW-1:0] tick_ff, slow_ff, press_start_ff, chaser_start_ff, pattern_ff;
   logic [CW-1:0] pause_ff, hold_start_ff, duty_ff, flash_ff;
   logic [1:0]    phase_ff;
   logic [SW-1:0] servo_ff;
   logic          press_seen_ff, chaser_run_ff, moving_ff, opening_ff;
   logic          stop_pend_ff, gate_ff;

   logic [CW-1:0] tick_in, slow_in, press_start_in, chaser_start_in, pattern_in;
   logic [CW-1:0] pause_in, hold_start_in, duty_in, flash_in;
   logic [1:0]    phase_in;
   logic [SW-1:0] servo_in;
   logic          press_seen_in, chaser_run_in, moving_in, opening_in;
   logic          stop_pend_in, gate_in;
   logic          pwm_in, steady_in;

   // servo arithmetic: one add/compare for opening; an add, a subtract and a compare for closing
   logic [SW:0] open_sum, close_floor;
   logic [SW:0] close_diff;

   assign open_sum    = {1'b0, servo_ff} + {1'b0, servo_step_ff};
   assign close_floor = {1'b0, servo_low_ff} + {1'b0, servo_step_ff};
   assign close_diff  = {1'b0, servo_ff} - {1'b0, servo_step_ff};

   always_comb begin
      logic [CW-1:0] dur, ran, held, sum8, diff8;

      tick_in         = tick_ff + CW'(1);
      slow_in         = (tick_in == '0) ? slow_ff + CW'(1) : slow_ff;
      press_start_in  = press_start_ff;
      press_seen_in   = press_seen_ff;
      chaser_run_in   = chaser_run_ff;
      chaser_start_in = chaser_start_ff;
      pattern_in      = pattern_ff;
      pause_in        = pause_ff;
      phase_in        = phase_ff;
      hold_start_in   = hold_start_ff;
      duty_in         = duty_ff;
      servo_in        = servo_ff;
      moving_in       = moving_ff;
      opening_in      = opening_ff;
      stop_pend_in    = stop_pend_ff;
      flash_in        = flash_ff;
      gate_in         = gate_ff;
      pwm_in          = 1'b0;
      steady_in       = 1'b0;
      dur             = tick_in - press_start_ff;

      // buttons; inner button wins and drops any outer press
      if (in_inner_ff) begin
         if (phase_in != bsgl_pkg::PH_ON) phase_in = bsgl_pkg::PH_RISE;
         else hold_start_in = slow_in;
         press_seen_in = 1'b0;
      end else if (in_outer_ff) begin
         if (!press_seen_ff) begin
            press_start_in = tick_in;
            press_seen_in  = 1'b1;
         end
      end else begin
         if (press_seen_ff && dur > bsgl_pkg::PRESS_MIN_TICKS) begin
            if (dur < bsgl_pkg::PRESS_LONG_TICKS) begin
               // short press toggles the chaser
               if (chaser_run_ff) begin
                  chaser_run_in = 1'b0;
               end else begin
                  chaser_run_in   = 1'b1;
                  chaser_start_in = slow_in;
                  pattern_in      = '0;
               end
            end else begin
               // long press reverses the gate
               opening_in = !opening_ff;
               moving_in  = 1'b1;
               if (flash_ff == '0) flash_in = FLASH_LOAD;
               if (opening_in) begin
                  if (phase_in != bsgl_pkg::PH_ON) phase_in = bsgl_pkg::PH_RISE;
                  else hold_start_in = slow_in;
               end else if (phase_in == bsgl_pkg::PH_RISE ||
                            phase_in == bsgl_pkg::PH_ON) begin
                  phase_in = bsgl_pkg::PH_FALL;
               end
            end
         end
         press_seen_in = 1'b0;
      end

      // servo: stop takes effect on the tick after an end is reached
      if (stop_pend_ff) begin
         moving_in    = 1'b0;
         stop_pend_in = 1'b0;
      end
      if (moving_in) begin
         if (opening_in) begin
            if (open_sum > {1'b0, servo_high_ff}) begin
               servo_in     = servo_high_ff;
               stop_pend_in = 1'b1;
            end else begin
               servo_in = open_sum[SW-1:0];
            end
         end else begin
            if ({1'b0, servo_ff} < close_floor) begin
               servo_in     = servo_low_ff;
               stop_pend_in = 1'b1;
            end else begin
               servo_in = close_diff[SW-1:0];
            end
         end
      end

      // chaser walk
      ran = slow_in - chaser_start_in;
      if (chaser_run_in) begin
         pause_in = pause_ff - CW'(1);
         if (pause_in == '0) begin
            pause_in   = chaser_pause_cfg_ff;
            pattern_in = pattern_in << 1;
            if (pattern_in > CHASER_LAST) begin
               if (ran >= chaser_on_ff) begin
                  pattern_in    = '0;
                  chaser_run_in = 1'b0;
               end else begin
                  pattern_in = CW'(1);
               end
            end else if (pattern_in == '0) begin
               // zero pattern (fresh start or shifted out of the register): restart, no timeout check
               pattern_in = CW'(1);
            end
         end
      end

      // inner LED fade
      sum8  = duty_ff + rise_step_ff;
      diff8 = duty_ff - fall_step_ff;
      held  = slow_in - hold_start_in;
      unique case (phase_in)
         bsgl_pkg::PH_RISE: begin
            pwm_in  = 1'b1;
            duty_in = sum8;
            if (sum8 < rise_step_ff) begin
               duty_in       = bsgl_pkg::DUTY_FULL;
               hold_start_in = slow_in;
               phase_in      = bsgl_pkg::PH_ON;
            end
         end
         bsgl_pkg::PH_FALL: begin
            pwm_in  = 1'b1;
            duty_in = diff8;
            if (diff8 > duty_ff) begin
               duty_in  = '0;
               phase_in = bsgl_pkg::PH_IDLE;
            end
         end
         bsgl_pkg::PH_ON: begin
            steady_in = 1'b1;
            if (held >= hold_on_ff) phase_in = bsgl_pkg::PH_FALL;
         end
         bsgl_pkg::PH_IDLE: ;
         default: ;
      endcase

      // gate LED blink; finishes at the end of the blink period in which the servo stops
      if (flash_in != '0) begin
         flash_in = flash_in - CW'(1);
         if (flash_in == '0) begin
            if (moving_in) begin
               flash_in = FLASH_LOAD;
               gate_in  = !gate_ff;
            end else begin
               gate_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff         <= '0;
         slow_ff         <= '0;
         press_start_ff  <= '0;
         press_seen_ff   <= 1'b0;
         chaser_run_ff   <= 1'b0;
         chaser_start_ff <= '0;
         pattern_ff      <= CW'(1);
         pause_ff        <= bsgl_pkg::CHASER_PAUSE_RESET;
         phase_ff        <= bsgl_pkg::PH_IDLE;
         hold_start_ff   <= '0;
         duty_ff         <= '0;
         servo_ff        <= bsgl_pkg::SERVO_LOW_RESET;
         moving_ff       <= 1'b0;
         opening_ff      <= 1'b1;
         stop_pend_ff    <= 1'b0;
         flash_ff        <= '0;
         gate_ff         <= 1'b0;
      end else if (advance) begin
         tick_ff         <= tick_in;
         slow_ff         <= slow_in;
         press_start_ff  <= press_start_in;
         press_seen_ff   <= press_seen_in;
         chaser_run_ff   <= chaser_run_in;
         chaser_start_ff <= chaser_start_in;
         pattern_ff      <= pattern_in;
         pause_ff        <= pause_in;
         phase_ff        <= phase_in;
         hold_start_ff   <= hold_start_in;
         duty_ff         <= duty_in;
         servo_ff        <= servo_in;
         moving_ff       <= moving_in;
         opening_ff      <= opening_in;
         stop_pend_ff    <= stop_pend_in;
         flash_ff        <= flash_in;
         gate_ff         <= gate_in;
      end
   end

   // ---------------- result register ----------------
   logic [CHASER_LEDS-1:0] leds_ff;
   logic                   pwm_ff, steady_ff, deep_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         leds_ff   <= chaser_run_in ? pattern_in[CHASER_LEDS-1:0] : '0;
         pwm_ff    <= pwm_in;
         steady_ff <= steady_in;
         deep_ff   <= !chaser_run_in && !moving_in && !press_seen_in &&
                      (phase_in == bsgl_pkg::PH_IDLE);
      end
   end

   // servo, duty and gate outputs are the live state registers
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.servo_width      = servo_ff;
   assign rsp_ch.servo_powered    = moving_ff;
   assign rsp_ch.chaser_leds      = leds_ff;
   assign rsp_ch.fade_duty        = duty_ff;
   assign rsp_ch.fade_pwm_active  = pwm_ff;
   assign rsp_ch.inner_led_steady = steady_ff;
   assign rsp_ch.gate_led         = gate_ff;
   assign rsp_ch.deep_sleep_ok    = deep_ff;

   // ---------------- checks ----------------
   `BSGL_ASSERT_NEXT(a_stop_unpowers, clock, reset, stop_pend_ff && advance, !moving_ff)
   `BSGL_ASSERT_NEXT(a_held_item_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `BSGL_ASSERT_NOW(a_gate_needs_timer, clock, reset, gate_ff, flash_ff != '0)
   `BSGL_ASSERT_NOW(a_sleep_all_off, clock, reset, rsp_valid_ff && deep_ff,
                    leds_ff == '0 && !moving_ff)

endmodule
